// ===== hdl/lpe_pkg.sv =====
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types, register codes and helpers for the LED pixel SPI encoder.
// ----------------------------------------------------------------------------
package lpe_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_ORDER = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GUARD_LEN   = 2'd2;

    localparam int PIXEL_COUNT_W = 11;
    localparam int GUARD_W       = 5;

    localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RESET = 11'd1;
    localparam logic [GUARD_W-1:0]       GUARD_LIMIT       = 5'd16;

    // wide enough for pixel index + 1 and any frame length limit
    localparam int CMP_W = 17;

    // color order codes
    localparam logic ORDER_RGB = 1'b0;
    localparam logic ORDER_GRB = 1'b1;

    // bit cell nibbles
    localparam logic [3:0] NIBBLE_ONE  = 4'hC;
    localparam logic [3:0] NIBBLE_ZERO = 4'h8;

    // index of the last of the twelve data bytes of a pixel
    localparam logic [GUARD_W-1:0] DATA_LAST = 5'd11;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       last_byte;
    } spi_beat_t;

    // one pixel job handed from front to back
    typedef struct packed {
        logic [23:0]        bits;      // channel bytes in wire order, MSB first
        logic [GUARD_W-1:0] lead;      // guard zeros before the data
        logic [GUARD_W-1:0] trail;     // guard zeros after the data
        logic               fin_data;  // last data byte closes the frame
    } cmd_t;

    function automatic logic [7:0] encode_pair(input logic [1:0] b);
        logic [3:0] hi;
        logic [3:0] lo;
        hi = b[1] ? NIBBLE_ONE : NIBBLE_ZERO;
        lo = b[0] ? NIBBLE_ONE : NIBBLE_ZERO;
        return {hi, lo};
    endfunction

endpackage

// ===== hdl/led_pixel_spi_bit_encoder.sv =====
// ----------------------------------------------------------------------------
// led_pixel_spi_bit_encoder
// RGB pixels in, nibble-encoded SPI bytes for an LED strip out, framed by
// guard zero bytes before and after each frame.
// ----------------------------------------------------------------------------
//  channel   ports            beat                         handshake
//  pixel in  s_valid/s_ready  s_data: red, green, blue     valid/ready
//  bytes out m_valid/m_ready  m_data: byte_out, last_byte  valid/ready
//  config    cfg_wr_en        cfg_index, cfg_data          write, no wait
//
//  One output byte per cycle while the output is not stalled: a pixel is
//  twelve data bytes, plus one guard zero byte per guard when it opens a
//  frame and again when it closes one. A two-entry job queue lets pixels be
//  taken while the sequencer works and while an output beat is stalled.
//  Reset is synchronous and clears control state only; no clearing pass.
// ----------------------------------------------------------------------------
module led_pixel_spi_bit_encoder
    import lpe_pkg::*;
#(
    parameter int MAX_PIXELS = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  pixel_t                 s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output spi_beat_t              m_data
);

    logic accept;
    logic q_full;
    logic q_avail;
    logic q_pop;
    cmd_t front_cmd;
    cmd_t q_head;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    lpe_front #(
        .MAX_PIXELS(MAX_PIXELS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pixel     (s_data),
        .cmd       (front_cmd)
    );

    lpe_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .head     (q_head)
    );

    lpe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_avail (q_avail),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== hdl/lpe_front.sv =====
// ----------------------------------------------------------------------------
// lpe_front
// Holds the registers and the frame position, classifies each pixel
// (first / last in frame) and builds the job for the byte sequencer.
// ----------------------------------------------------------------------------
module lpe_front
    import lpe_pkg::*;
#(
    parameter int MAX_PIXELS = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   accept,
    input  pixel_t                 pixel,
    output cmd_t                   cmd
);

    localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_PIXELS);

    logic [PIXEL_COUNT_W-1:0] pixel_count_reg;
    logic                     color_order_reg;
    logic [GUARD_W-1:0]       guard_len_reg;
    logic [IDX_W-1:0]         pixel_index_reg;
    logic [IDX_W-1:0]         pixel_index_next;

    logic [PIXEL_COUNT_W-1:0] count_nz;
    logic [CMP_W-1:0]         frame_len;
    logic [CMP_W-1:0]         pos_plus1;
    logic [GUARD_W-1:0]       guards;
    logic                     first_pix;
    logic                     last_pix;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg <= PIXEL_COUNT_RESET;
            color_order_reg <= ORDER_RGB;
            guard_len_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PIXEL_COUNT: pixel_count_reg <= cfg_data;
                CFG_COLOR_ORDER: color_order_reg <= cfg_data[0];
                CFG_GUARD_LEN:   guard_len_reg   <= cfg_data[GUARD_W-1:0];
                default: ;
            endcase
        end
    end

    // frame length clamped to 1..MAX_PIXELS, guard size clamped to the limit
    always_comb begin
        count_nz  = (pixel_count_reg == '0) ? PIXEL_COUNT_W'(1) : pixel_count_reg;
        frame_len = (CMP_W'(count_nz) > MAX_LEN) ? MAX_LEN : CMP_W'(count_nz);
        pos_plus1 = CMP_W'(pixel_index_reg) + CMP_W'(1);
        guards    = (guard_len_reg > GUARD_LIMIT) ? GUARD_LIMIT : guard_len_reg;
        first_pix = (pixel_index_reg == '0);
        last_pix  = (pos_plus1 >= frame_len);
    end

    // job for the sequencer
    always_comb begin
        if (color_order_reg == ORDER_GRB) begin
            cmd.bits = {pixel.green, pixel.red, pixel.blue};
        end else begin
            cmd.bits = {pixel.red, pixel.green, pixel.blue};
        end
        cmd.lead     = first_pix ? guards : '0;
        cmd.trail    = last_pix ? guards : '0;
        cmd.fin_data = last_pix && (guards == '0);
    end

    // frame position
    assign pixel_index_next = last_pix ? '0 : pixel_index_reg + IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_index_reg <= '0;
        end else if (accept) begin
            pixel_index_reg <= pixel_index_next;
        end
    end

endmodule

// ===== hdl/lpe_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lpe_cmd_fifo
// Two-entry job queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module lpe_cmd_fifo
    import lpe_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic avail,
    output cmd_t head
);

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign avail = (count_reg != 2'd0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/lpe_back.sv =====
// ----------------------------------------------------------------------------
// lpe_back
// Byte sequencer: leading guards, twelve encoded data bytes, trailing
// guards, one byte per cycle into a registered output stage unless it stalls.
// ----------------------------------------------------------------------------
module lpe_back
    import lpe_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_avail,
    input  cmd_t      q_head,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output spi_beat_t m_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEAD,
        ST_DATA,
        ST_TRAIL
    } state_t;

    state_t             state_reg, state_next;
    logic [GUARD_W-1:0] cnt_reg, cnt_next;
    logic [23:0]        bits_reg, bits_next;
    logic [GUARD_W-1:0] lead_reg, lead_next;
    logic [GUARD_W-1:0] trail_reg, trail_next;
    logic               fin_reg, fin_next;
    logic               m_valid_reg, m_valid_next;
    spi_beat_t          m_data_reg, m_data_next;

    logic      out_free;
    logic      emit;
    logic      done;
    logic      load;
    spi_beat_t beat;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (state_reg != ST_IDLE) && out_free;

    // byte for the current step
    always_comb begin
        beat = '0;
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE: ;
            ST_LEAD: ;
            ST_DATA: begin
                beat.byte_out  = encode_pair(bits_reg[23:22]);
                beat.last_byte = fin_reg && (cnt_reg == DATA_LAST);
                done           = (cnt_reg == DATA_LAST) && (trail_reg == '0);
            end
            ST_TRAIL: begin
                beat.last_byte = (cnt_reg == trail_reg - GUARD_W'(1));
                done           = beat.last_byte;
            end
            default: ;
        endcase
    end

    assign load  = q_avail && ((state_reg == ST_IDLE) || (emit && done));
    assign q_pop = load;

    // sequencer next state
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        bits_next    = bits_reg;
        lead_next    = lead_reg;
        trail_next   = trail_reg;
        fin_next     = fin_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = beat;
            cnt_next     = cnt_reg + GUARD_W'(1);
            unique case (state_reg)
                ST_LEAD: begin
                    if (cnt_reg == lead_reg - GUARD_W'(1)) begin
                        state_next = ST_DATA;
                        cnt_next   = '0;
                    end
                end
                ST_DATA: begin
                    bits_next = {bits_reg[21:0], 2'b00};
                    if (cnt_reg == DATA_LAST) begin
                        state_next = (trail_reg == '0) ? ST_IDLE : ST_TRAIL;
                        cnt_next   = '0;
                    end
                end
                ST_TRAIL: begin
                    if (done) state_next = ST_IDLE;
                end
                default: ;
            endcase
        end

        // take the next job, possibly in the cycle the current one ends
        if (load) begin
            state_next = (q_head.lead == '0) ? ST_DATA : ST_LEAD;
            cnt_next   = '0;
            bits_next  = q_head.bits;
            lead_next  = q_head.lead;
            trail_next = q_head.trail;
            fin_next   = q_head.fin_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        bits_reg   <= bits_next;
        lead_reg   <= lead_next;
        trail_reg  <= trail_next;
        fin_reg    <= fin_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/lpe_checker.sv =====
// ----------------------------------------------------------------------------
// lpe_checker
// Port-level checks for the LED pixel SPI encoder, bound to the top level.
// ----------------------------------------------------------------------------
module lpe_checker
    import lpe_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input spi_beat_t m_data
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output beat changed while stalled");

    // no output beat right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // every beat is a guard zero or two well-formed bit cells
    a_byte_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.byte_out == 8'h00) ||
                    (((m_data.byte_out[7:4] == NIBBLE_ONE) ||
                      (m_data.byte_out[7:4] == NIBBLE_ZERO)) &&
                     ((m_data.byte_out[3:0] == NIBBLE_ONE) ||
                      (m_data.byte_out[3:0] == NIBBLE_ZERO))))
        else $error("malformed output byte");

endmodule

bind led_pixel_spi_bit_encoder lpe_checker u_lpe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for led_pixel_spi_bit_encoder. A directed table runs
// first: field extremes, both channel orders, guard framing and saturation,
// zero and oversize pixel counts, a count lowered mid-frame, mid-frame
// register writes and an unused register index. Random register phases with
// random pixels follow. Each output beat is checked against typed-row bytes
// or an in-bench encoder model, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb;
    import lpe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PIXELS    = 1024;
    localparam int RANDOM_PIXELS = 200;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int BYTES_PER_PIX = 12;

    // index past the end of the register map, must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

    // one directed step; typed rows carry their expected bytes in short form
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        pixel_t                 px;
        logic                   typed;
        logic [4:0]             lead;     // leading guard zeros
        logic [7:0]             fill;     // every data byte
        logic [4:0]             trail;    // trailing guard zeros
        logic                   fin;      // pixel closes the frame
    } stim_row_t;

    localparam int DIR_ROWS = 27;

    stim_row_t dir_rows [DIR_ROWS] = '{
        // reset state: one-pixel frames, RGB, no guards
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'hFFFFFF, 1'b1, 5'd0, 8'hCC, 5'd0, 1'b1},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'h000000, 1'b1, 5'd0, 8'h88, 5'd0, 1'b1},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'hAA550F, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        // green first
        '{ROW_WRITE, CFG_COLOR_ORDER, 11'(ORDER_GRB), 24'h0, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'h123456, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        // three-pixel frame with full guards
        '{ROW_WRITE, CFG_GUARD_LEN, 11'd16, 24'h0, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_WRITE, CFG_PIXEL_COUNT, 11'd3, 24'h0, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'hFFFFFF, 1'b1, 5'd16, 8'hCC, 5'd0, 1'b0},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'h000000, 1'b1, 5'd0, 8'h88, 5'd0, 1'b0},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'h000000, 1'b1, 5'd0, 8'h88, 5'd16, 1'b1},
        // guard saturates at 16, zero count acts as one
        '{ROW_WRITE, CFG_GUARD_LEN, 11'd31, 24'h0, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_WRITE, CFG_PIXEL_COUNT, 11'd0, 24'h0, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'h000000, 1'b1, 5'd16, 8'h88, 5'd16, 1'b1},
        // oversize count saturates, then lowered under the current position
        '{ROW_WRITE, CFG_PIXEL_COUNT, 11'd2047, 24'h0, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_WRITE, CFG_GUARD_LEN, 11'd1, 24'h0, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'h80017E, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'hFF00FF, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_WRITE, CFG_PIXEL_COUNT, 11'd2, 24'h0, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'hFFFFFF, 1'b1, 5'd0, 8'hCC, 5'd1, 1'b1},
        // write to an unmapped index changes nothing
        '{ROW_WRITE, CFG_UNUSED, 11'h7FF, 24'h0, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'h000000, 1'b1, 5'd1, 8'h88, 5'd0, 1'b0},
        // guards dropped mid-frame: last flag moves onto the final data byte
        '{ROW_WRITE, CFG_GUARD_LEN, 11'd0, 24'h0, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'hFFFFFF, 1'b1, 5'd0, 8'hCC, 5'd0, 1'b1},
        // largest legal count
        '{ROW_WRITE, CFG_COLOR_ORDER, 11'(ORDER_RGB), 24'h0, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_WRITE, CFG_PIXEL_COUNT, 11'd1024, 24'h0, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'hC3A5F0, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0},
        '{ROW_PIXEL, CFG_PIXEL_COUNT, 11'd0, 24'h0F0F0F, 1'b0, 5'd0, 8'h00, 5'd0, 1'b0}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    pixel_t                 s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b1;
    spi_beat_t              m_data;

    // register mirror and frame position
    logic [PIXEL_COUNT_W-1:0] mir_count = PIXEL_COUNT_RESET;
    logic                     mir_order = ORDER_RGB;
    logic [GUARD_W-1:0]       mir_guard = '0;
    logic [9:0]               frame_pos = '0;

    spi_beat_t   spi_byte_q [$];
    spi_beat_t   want_beat;
    int          err_cnt    = 0;
    int          cycle_cnt  = 0;
    int unsigned stall_left = 0;
    int unsigned pause;
    bit          steady     = 1'b0;   // no gaps or stalls in this phase

    led_pixel_spi_bit_encoder #(
        .MAX_PIXELS(MAX_PIXELS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        if (err_cnt < 20) $display("[%0t] MISMATCH: %s", $realtime, what);
        err_cnt++;
    endtask

    // SPI bytes for one pixel at the current frame position; advances the frame
    function automatic void encode_pixel(input pixel_t px, input bit record);
        logic [2:0][7:0] chan;
        int unsigned     frame_len;
        int unsigned     guards;
        int unsigned     pos_next;
        int unsigned     hi;
        logic            closes;
        logic            fin;
        logic [7:0]      v;
        frame_len = (mir_count == 0) ? 1 :
                    (mir_count > MAX_PIXELS) ? MAX_PIXELS : mir_count;
        guards    = (mir_guard > GUARD_LIMIT) ? GUARD_LIMIT : mir_guard;
        pos_next  = frame_pos + 1;
        closes    = (pos_next >= frame_len);
        chan[0]   = (mir_order == ORDER_RGB) ? px.red : px.green;
        chan[1]   = (mir_order == ORDER_RGB) ? px.green : px.red;
        chan[2]   = px.blue;
        if (record) begin
            if (frame_pos == 0) begin
                repeat (guards) spi_byte_q.push_back(spi_beat_t'{8'h00, 1'b0});
            end
            // two bits per byte, MSB first, higher bit in the high nibble
            for (int c = 0; c < 3; c++) begin
                for (int p = 0; p < 4; p++) begin
                    hi  = 7 - 2 * p;
                    v   = {chan[c][hi] ? NIBBLE_ONE : NIBBLE_ZERO,
                           chan[c][hi-1] ? NIBBLE_ONE : NIBBLE_ZERO};
                    fin = closes && guards == 0 && c == 2 && p == 3;
                    spi_byte_q.push_back(spi_beat_t'{v, fin});
                end
            end
            if (closes) begin
                for (int i = 0; i < guards; i++)
                    spi_byte_q.push_back(spi_beat_t'{8'h00, i + 1 == guards});
            end
        end
        frame_pos = closes ? 10'd0 : frame_pos + 10'd1;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_PIXEL_COUNT: mir_count = val[PIXEL_COUNT_W-1:0];
            CFG_COLOR_ORDER: mir_order = val[0];
            CFG_GUARD_LEN:   mir_guard = val[GUARD_W-1:0];
            default: ;
        endcase
    endtask

    // valid stays up across back-to-back beats; dropped for a gap or a drain
    task automatic send_pixel(input pixel_t px);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // block is idle once every expected byte has come out
    task automatic drain_bytes();
        s_valid <= 1'b0;
        do @(posedge aclk); while (spi_byte_q.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    // sink: check each accepted beat, then maybe stall outside steady phases
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (spi_byte_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat byte_out=%02h last=%0b",
                                              m_data.byte_out, m_data.last_byte));
                end else begin
                    want_beat = spi_byte_q.pop_front();
                    if (m_data.byte_out !== want_beat.byte_out)
                        report_mismatch($sformatf("byte_out %02h, expected %02h",
                                                  m_data.byte_out, want_beat.byte_out));
                    if (m_data.last_byte !== want_beat.last_byte)
                        report_mismatch($sformatf("last_byte %0b, expected %0b (byte %02h)",
                                                  m_data.last_byte, want_beat.last_byte,
                                                  want_beat.byte_out));
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                if (stall_left == 1) m_ready <= 1'b1;
            end else if (m_valid && m_ready && !steady) begin
                pause = $urandom_range(0, 3);
                if (pause != 0) begin
                    m_ready    <= 1'b0;
                    stall_left <= pause;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** led_pixel_spi_bit_encoder: FAILED **");
            $finish;
        end
    end

    initial begin
        stim_row_t              r;
        pixel_t                 px;
        int                     sent;
        int                     burst;
        logic [CFG_DATA_W-1:0]  val;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (dir_rows[n]) begin
            r = dir_rows[n];
            if (r.kind == ROW_WRITE) begin
                drain_bytes();
                write_reg(r.reg_idx, r.reg_val);
            end else begin
                encode_pixel(r.px, !r.typed);
                if (r.typed) begin
                    repeat (r.lead) spi_byte_q.push_back(spi_beat_t'{8'h00, 1'b0});
                    for (int k = 0; k < BYTES_PER_PIX; k++)
                        spi_byte_q.push_back(spi_beat_t'{r.fill,
                            r.fin && r.trail == 0 && k == BYTES_PER_PIX - 1});
                    for (int k = 0; k < r.trail; k++)
                        spi_byte_q.push_back(spi_beat_t'{8'h00, r.fin && k == r.trail - 1});
                end
                send_pixel(r.px);
            end
        end

        // random phases: registers rewritten while idle, then a pixel burst
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            drain_bytes();
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       val = '0;
                    1:       val = ($urandom_range(0, 1) != 0) ? 11'd1024 : 11'd2047;
                    2:       val = 11'($urandom_range(1, 2047));
                    default: val = 11'($urandom_range(1, 6));
                endcase
                write_reg(CFG_PIXEL_COUNT, val);
            end
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_COLOR_ORDER, 11'($urandom));
            if ($urandom_range(0, 2) != 0) begin
                val = 11'($urandom);
                case ($urandom_range(0, 7))
                    0:       val[GUARD_W-1:0] = 5'($urandom_range(17, 31));
                    1:       val[GUARD_W-1:0] = GUARD_LIMIT;
                    2:       val[GUARD_W-1:0] = '0;
                    default: val[GUARD_W-1:0] = 5'($urandom_range(0, 16));
                endcase
                write_reg(CFG_GUARD_LEN, val);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNUSED, 11'($urandom));
            burst = $urandom_range(4, 16);
            repeat (burst) begin
                case ($urandom_range(0, 7))
                    0:       px = '0;
                    1:       px = '1;
                    default: px = pixel_t'($urandom);
                endcase
                encode_pixel(px, 1'b1);
                send_pixel(px);
                sent++;
            end
        end

        drain_bytes();
        repeat (40) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("** led_pixel_spi_bit_encoder: PASSED **");
        end else begin
            $display("** led_pixel_spi_bit_encoder: FAILED **");
        end
        $finish;
    end

endmodule
